/* sv/slfr_pkg.sv */
`timescale 1ns / 1ps

package slfr_pkg;

  localparam int unsigned VAL_W      = 32;
  localparam int unsigned DIF_W      = 33;
  localparam int unsigned DEN_W      = 34;
  localparam int unsigned ACC_W      = 35;
  localparam int unsigned BIAS_W     = 16;
  localparam int unsigned PROD_SPLIT = 30;

  localparam logic [BIAS_W-1:0] BIAS_RST = 16'd1;
  localparam logic [VAL_W-1:0]  VAL_MAX  = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0]  VAL_MIN  = 32'h8000_0000;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_ONE  = 2'd1,
    CLS_DIV  = 2'd2
  } cls_e;

  typedef struct packed {
    logic [VAL_W-1:0] left_value;
    logic [VAL_W-1:0] center_value;
    logic [VAL_W-1:0] right_value;
    logic [VAL_W-1:0] left_tangent;
    logic [VAL_W-1:0] center_tangent;
    logic [VAL_W-1:0] right_tangent;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [VAL_W-1:0] c;
    logic [VAL_W-1:0] tc;
    logic [DIF_W-1:0] rc;
    logic [DIF_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
    logic             den_neg;
    logic [DIF_W-1:0] tca;
    logic [DIF_W-1:0] dt;
    cls_e             cls;
    logic             last;
  } qent_t;

  typedef struct packed {
    logic [VAL_W-1:0] c;
    logic [VAL_W-1:0] tc;
    logic [DIF_W-1:0] rc;
    logic             den_neg;
    logic [DIF_W-1:0] tca;
    logic [DIF_W-1:0] dt;
    cls_e             cls;
    logic             last;
  } d1_pay_t;

  typedef struct packed {
    logic [VAL_W-1:0] c;
    logic [VAL_W-1:0] tc;
    logic [DIF_W-1:0] rc_mag;
    logic             p2_neg;
    logic             interior;
    logic [DEN_W-1:0] mp;
    logic [DEN_W-1:0] hs;
    logic             last;
  } d2_pay_t;

  typedef struct packed {
    logic [VAL_W-1:0] left_face;
    logic [VAL_W-1:0] right_face;
    logic [VAL_W-1:0] left_face_tangent;
    logic [VAL_W-1:0] right_face_tangent;
    logic             last;
  } res_t;

  function automatic logic [VAL_W-1:0] sat32(input logic [65:0] v);
    logic [VAL_W-1:0] r;
    if (v[65] && !(&v[64:31])) begin
      r = VAL_MIN;
    end else if (!v[65] && (|v[64:31])) begin
      r = VAL_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* sv/slope_limited_face_reconstruction_top.sv */
`timescale 1ns / 1ps

// Minmod slope-limited face reconstruction with forward tangents.
// Input channel: push/full. An item (three cell values, three tangents and
// last_component) is taken on a clock edge with push high and full low.
// Result channel: empty/pop. While empty is low the oldest result is on the
// result ports; it is taken on a clock edge with pop high.
// Configuration: cfg_valid_i/cfg_ready_o carry denominator_bias; ready is
// always high. Write it only while no item is in flight.
// Throughput: one item per cycle while the output queue has room, set by fully
// pipelined dividers (one quotient bit per stage) for the limiter ratio and
// its derivative. Path from push to result: input queue, ratio divider, m1,
// m2, derivative divider, m3, m4, m5, output queue.
// Reset empties both queues and the pipeline; denominator_bias returns to 1.
// When the receiver stalls, the whole pipeline holds, the input queue fills
// and full rises; no item is lost.
module slope_limited_face_reconstruction_top import slfr_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [BIAS_W-1:0]  cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] left_value_i,
  input  logic signed [31:0] center_value_i,
  input  logic signed [31:0] right_value_i,
  input  logic signed [31:0] left_tangent_i,
  input  logic signed [31:0] center_tangent_i,
  input  logic signed [31:0] right_tangent_i,
  input  logic               last_component_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] left_face_o,
  output logic signed [31:0] right_face_o,
  output logic signed [31:0] left_face_tangent_o,
  output logic signed [31:0] right_face_tangent_o,
  output logic               last_out_o
);

  item_t item;
  qent_t ent, q_data;
  logic  q_wr, q_full, q_empty, q_pop;
  logic  adv, o_full, res_valid;
  res_t  res, out_data;

  always_comb begin
    item.left_value     = left_value_i;
    item.center_value   = center_value_i;
    item.right_value    = right_value_i;
    item.left_tangent   = left_tangent_i;
    item.center_tangent = center_tangent_i;
    item.right_tangent  = right_tangent_i;
    item.last           = last_component_i;
  end

  slfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .full_i      (q_full),
    .item_i      (item),
    .wr_o        (q_wr),
    .ent_o       (ent)
  );

  slfr_fifo #(
    .WIDTH ($bits(qent_t)),
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_wr),
    .data_i  (ent),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .empty_o (q_empty)
  );

  assign full = q_full;
  assign adv  = !o_full;

  slfr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .q_valid_i   (!q_empty),
    .q_data_i    (q_data),
    .qpop_o      (q_pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  slfr_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid && adv),
    .data_i  (res),
    .full_o  (o_full),
    .pop_i   (pop),
    .data_o  (out_data),
    .empty_o (empty)
  );

  assign left_face_o          = out_data.left_face;
  assign right_face_o         = out_data.right_face;
  assign left_face_tangent_o  = out_data.left_face_tangent;
  assign right_face_tangent_o = out_data.right_face_tangent;
  assign last_out_o           = out_data.last;

endmodule

/* sv/slfr_fifo.sv */
`timescale 1ns / 1ps

module slfr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* sv/slfr_div.sv */
`timescale 1ns / 1ps

module slfr_div #(
  parameter int unsigned DVD_W = 16,
  parameter int unsigned DEN_W = 34,
  parameter int unsigned PAY_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [DVD_W-1:0] dvd_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [PAY_W-1:0] pay_i,
  output logic             valid_o,
  output logic [DVD_W-1:0] quot_o,
  output logic [DEN_W-1:0] den_o,
  output logic [PAY_W-1:0] pay_o
);

  logic             vld_q   [DVD_W];
  logic [DEN_W-1:0] rem_q   [DVD_W];
  logic [DVD_W-1:0] dvd_q   [DVD_W];
  logic [DVD_W-1:0] quo_q   [DVD_W];
  logic [DEN_W-1:0] den_q   [DVD_W];
  logic [PAY_W-1:0] pay_q   [DVD_W];

  logic             src_vld [DVD_W];
  logic [DEN_W-1:0] src_rem [DVD_W];
  logic [DVD_W-1:0] src_dvd [DVD_W];
  logic [DVD_W-1:0] src_quo [DVD_W];
  logic [DEN_W-1:0] src_den [DVD_W];
  logic [PAY_W-1:0] src_pay [DVD_W];
  logic [DEN_W:0]   trial   [DVD_W];
  logic             take    [DVD_W];
  logic [DEN_W-1:0] rem_d   [DVD_W];
  logic [DVD_W-1:0] dvd_d   [DVD_W];
  logic [DVD_W-1:0] quo_d   [DVD_W];

  always_comb begin
    for (int k = 0; k < DVD_W; k++) begin
      if (k == 0) begin
        src_vld[k] = valid_i;
        src_rem[k] = rem_i;
        src_dvd[k] = dvd_i;
        src_quo[k] = '0;
        src_den[k] = den_i;
        src_pay[k] = pay_i;
      end else begin
        src_vld[k] = vld_q[k-1];
        src_rem[k] = rem_q[k-1];
        src_dvd[k] = dvd_q[k-1];
        src_quo[k] = quo_q[k-1];
        src_den[k] = den_q[k-1];
        src_pay[k] = pay_q[k-1];
      end
      trial[k] = {src_rem[k], src_dvd[k][DVD_W-1]};
      take[k]  = (trial[k] >= {1'b0, src_den[k]});
      rem_d[k] = take[k] ? DEN_W'(trial[k] - {1'b0, src_den[k]}) : trial[k][DEN_W-1:0];
      dvd_d[k] = src_dvd[k] << 1;
      quo_d[k] = {src_quo[k][DVD_W-2:0], take[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DVD_W; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      for (int k = 0; k < DVD_W; k++) begin
        vld_q[k] <= src_vld[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DVD_W; k++) begin
        rem_q[k] <= rem_d[k];
        dvd_q[k] <= dvd_d[k];
        quo_q[k] <= quo_d[k];
        den_q[k] <= src_den[k];
        pay_q[k] <= src_pay[k];
      end
    end
  end

  assign valid_o = vld_q[DVD_W-1];
  assign quot_o  = quo_q[DVD_W-1];
  assign den_o   = den_q[DVD_W-1];
  assign pay_o   = pay_q[DVD_W-1];

endmodule

/* sv/slfr_front.sv */
`timescale 1ns / 1ps

module slfr_front import slfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [BIAS_W-1:0] cfg_data_i,
  input  logic              push_i,
  input  logic              full_i,
  input  item_t             item_i,
  output logic              wr_o,
  output qent_t             ent_o
);

  logic [BIAS_W-1:0] bias_q;
  logic [DIF_W-1:0]  num, rc, tca, dt, num_mag;
  logic [DEN_W-1:0]  den, den_mag;
  logic              num_neg, num_zero, den_zero, same_sign;

  assign cfg_ready_o = 1'b1;
  assign wr_o        = push_i && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= BIAS_RST;
    end else if (cfg_valid_i) begin
      bias_q <= cfg_data_i;
    end
  end

  always_comb begin
    num = {item_i.center_value[31], item_i.center_value}
        - {item_i.left_value[31], item_i.left_value};
    rc  = {item_i.right_value[31], item_i.right_value}
        - {item_i.center_value[31], item_i.center_value};
    tca = {item_i.center_tangent[31], item_i.center_tangent}
        - {item_i.left_tangent[31], item_i.left_tangent};
    dt  = {item_i.right_tangent[31], item_i.right_tangent}
        - {item_i.center_tangent[31], item_i.center_tangent};
    den = {rc[DIF_W-1], rc} + {{(DEN_W-BIAS_W){1'b0}}, bias_q};

    num_neg   = num[DIF_W-1];
    num_zero  = (num == '0);
    den_zero  = (den == '0);
    num_mag   = num_neg ? -num : num;
    den_mag   = den[DEN_W-1] ? -den : den;
    same_sign = !num_zero && !den_zero && (num_neg == den[DEN_W-1]);

    ent_o.c       = item_i.center_value;
    ent_o.tc      = item_i.center_tangent;
    ent_o.rc      = rc;
    ent_o.num_mag = num_mag;
    ent_o.den_mag = den_mag;
    ent_o.den_neg = den[DEN_W-1];
    ent_o.tca     = tca;
    ent_o.dt      = dt;
    ent_o.last    = item_i.last;

    priority if (den_zero) begin
      ent_o.cls = (!num_neg && !num_zero) ? CLS_ONE : CLS_ZERO;
    end else if (!same_sign) begin
      ent_o.cls = CLS_ZERO;
    end else if ({1'b0, num_mag} >= den_mag) begin
      ent_o.cls = CLS_ONE;
    end else begin
      ent_o.cls = CLS_DIV;
    end
  end

endmodule

/* sv/slfr_back.sv */
`timescale 1ns / 1ps

module slfr_back import slfr_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  q_valid_i,
  input  qent_t q_data_i,
  output logic  qpop_o,
  output logic  res_valid_o,
  output res_t  res_o
);

  localparam int unsigned PHI_W = FRAC_BITS + 1;
  localparam int unsigned TPH_W = ACC_W + FRAC_BITS;
  localparam int unsigned HI_W  = TPH_W - PROD_SPLIT;
  localparam int unsigned PRD_W = DIF_W + TPH_W;
  localparam int unsigned PM_W  = 63 - FRAC_BITS;
  localparam logic [PHI_W-1:0] One     = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [PRD_W-1:0] ProdLim = {{(PRD_W-63){1'b0}}, 1'b1, {62{1'b0}}};

  // divider stage one: phi
  logic                 d1_vld;
  logic [FRAC_BITS-1:0] d1_quo;
  logic [DEN_W-1:0]     d1_den;
  logic [$bits(d1_pay_t)-1:0] d1_pay_vec;
  d1_pay_t              d1_in, d1_pay;

  assign qpop_o = en_i && q_valid_i;

  always_comb begin
    d1_in.c       = q_data_i.c;
    d1_in.tc      = q_data_i.tc;
    d1_in.rc      = q_data_i.rc;
    d1_in.den_neg = q_data_i.den_neg;
    d1_in.tca     = q_data_i.tca;
    d1_in.dt      = q_data_i.dt;
    d1_in.cls     = q_data_i.cls;
    d1_in.last    = q_data_i.last;
  end

  slfr_div #(
    .DVD_W (FRAC_BITS),
    .DEN_W (DEN_W),
    .PAY_W ($bits(d1_pay_t))
  ) u_div_phi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (q_valid_i),
    .rem_i   ({1'b0, q_data_i.num_mag}),
    .dvd_i   ('0),
    .den_i   (q_data_i.den_mag),
    .pay_i   (d1_in),
    .valid_o (d1_vld),
    .quot_o  (d1_quo),
    .den_o   (d1_den),
    .pay_o   (d1_pay_vec)
  );

  assign d1_pay = d1_pay_t'(d1_pay_vec);

  // m1: limit and first products
  logic [PHI_W-1:0]       phi;
  logic                   interior;
  logic [DIF_W-1:0]       dt_mag, rc_mag;
  logic                   m1_vld_q, m1_int_q;
  logic [PHI_W+DIF_W-1:0] m1_pdt_q, m1_prc_q;
  logic [DIF_W-1:0]       m1_rcm_q;
  logic [DEN_W-1:0]       m1_den_q;
  d1_pay_t                m1_pay_q;

  always_comb begin
    unique case (d1_pay.cls)
      CLS_ZERO: phi = '0;
      CLS_ONE:  phi = One;
      CLS_DIV:  phi = {1'b0, d1_quo};
      default:  phi = '0;
    endcase
    interior = (d1_pay.cls == CLS_DIV) && (d1_quo != '0);
    dt_mag   = d1_pay.dt[DIF_W-1] ? -d1_pay.dt : d1_pay.dt;
    rc_mag   = d1_pay.rc[DIF_W-1] ? -d1_pay.rc : d1_pay.rc;
  end

  // m2: tangent numerator
  logic [DIF_W:0]   mp_mag, mp;
  logic [DIF_W-1:0] hs_mag;
  logic [DEN_W-1:0] hs;
  logic [ACC_W-1:0] a_val, a_mag;
  logic             m2_vld_q, m2_int_q, m2_p2neg_q, m2_last_q;
  logic [VAL_W-1:0] m2_c_q, m2_tc_q;
  logic [DIF_W-1:0] m2_rcm_q;
  logic [DEN_W-1:0] m2_den_q, m2_mp_q, m2_hs_q;
  logic [ACC_W-1:0] m2_amag_q;

  always_comb begin
    mp_mag = m1_pdt_q[PHI_W+DIF_W-1:FRAC_BITS];
    mp     = m1_pay_q.dt[DIF_W-1] ? -mp_mag : mp_mag;
    hs_mag = m1_prc_q[PHI_W+DIF_W-1:FRAC_BITS+1];
    hs     = m1_pay_q.rc[DIF_W-1] ? -{1'b0, hs_mag} : {1'b0, hs_mag};
    a_val  = {{2{m1_pay_q.tca[DIF_W-1]}}, m1_pay_q.tca} - {mp[DIF_W], mp};
    a_mag  = a_val[ACC_W-1] ? -a_val : a_val;
  end

  // divider stage two: derivative of theta
  logic                       d2_vld;
  logic [TPH_W-1:0]           d2_quo;
  logic [DEN_W-1:0]           d2_den;
  logic [$bits(d2_pay_t)-1:0] d2_pay_vec;
  d2_pay_t                    d2_in, d2_pay;

  always_comb begin
    d2_in.c        = m2_c_q;
    d2_in.tc       = m2_tc_q;
    d2_in.rc_mag   = m2_rcm_q;
    d2_in.p2_neg   = m2_p2neg_q;
    d2_in.interior = m2_int_q;
    d2_in.mp       = m2_mp_q;
    d2_in.hs       = m2_hs_q;
    d2_in.last     = m2_last_q;
  end

  slfr_div #(
    .DVD_W (TPH_W),
    .DEN_W (DEN_W),
    .PAY_W ($bits(d2_pay_t))
  ) u_div_tphi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (m2_vld_q),
    .rem_i   ('0),
    .dvd_i   ({m2_amag_q, {FRAC_BITS{1'b0}}}),
    .den_i   (m2_den_q),
    .pay_i   (d2_in),
    .valid_o (d2_vld),
    .quot_o  (d2_quo),
    .den_o   (d2_den),
    .pay_o   (d2_pay_vec)
  );

  assign d2_pay = d2_pay_t'(d2_pay_vec);

  // m3: split product of the slope and the derivative
  logic [TPH_W-1:0]            tphi;
  logic                        m3_vld_q, m3_p2neg_q, m3_last_q;
  logic [DIF_W+PROD_SPLIT-1:0] m3_pplo_q;
  logic [DIF_W+HI_W-1:0]       m3_pphi_q;
  logic [VAL_W-1:0]            m3_c_q, m3_tc_q;
  logic [DEN_W-1:0]            m3_mp_q, m3_hs_q;

  assign tphi = d2_pay.interior ? d2_quo : '0;

  // m4: recombine, clamp, scale
  logic [PRD_W-1:0] prod, prod_cl;
  logic [PM_W-1:0]  pm;
  logic [63:0]      pm_ext, p2;
  logic             m4_vld_q, m4_last_q;
  logic [VAL_W-1:0] m4_c_q, m4_tc_q;
  logic [DEN_W-1:0] m4_mp_q, m4_hs_q;
  logic [63:0]      m4_p2_q;

  always_comb begin
    prod    = {m3_pphi_q, {PROD_SPLIT{1'b0}}} + {{HI_W{1'b0}}, m3_pplo_q};
    prod_cl = (prod > ProdLim) ? ProdLim : prod;
    pm      = prod_cl[62:FRAC_BITS];
    pm_ext  = {{(64-PM_W){1'b0}}, pm};
    p2      = m3_p2neg_q ? -pm_ext : pm_ext;
  end

  // m5: halve the tangent sum toward zero
  logic [64:0]      tsum, tsum_adj;
  logic             m5_vld_q, m5_last_q;
  logic [VAL_W-1:0] m5_c_q, m5_tc_q;
  logic [DEN_W-1:0] m5_hs_q;
  logic [63:0]      m5_ts_q;

  always_comb begin
    tsum     = {{31{m4_mp_q[DEN_W-1]}}, m4_mp_q} + {m4_p2_q[63], m4_p2_q};
    tsum_adj = tsum + {64'b0, tsum[64]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
      m3_vld_q <= 1'b0;
      m4_vld_q <= 1'b0;
      m5_vld_q <= 1'b0;
    end else if (en_i) begin
      m1_vld_q <= d1_vld;
      m2_vld_q <= m1_vld_q;
      m3_vld_q <= d2_vld;
      m4_vld_q <= m3_vld_q;
      m5_vld_q <= m4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_int_q   <= interior;
      m1_pdt_q   <= {{DIF_W{1'b0}}, phi} * {{PHI_W{1'b0}}, dt_mag};
      m1_prc_q   <= {{DIF_W{1'b0}}, phi} * {{PHI_W{1'b0}}, rc_mag};
      m1_rcm_q   <= rc_mag;
      m1_den_q   <= d1_den;
      m1_pay_q   <= d1_pay;

      m2_int_q   <= m1_int_q;
      m2_p2neg_q <= m1_pay_q.rc[DIF_W-1] ^ a_val[ACC_W-1] ^ m1_pay_q.den_neg;
      m2_last_q  <= m1_pay_q.last;
      m2_c_q     <= m1_pay_q.c;
      m2_tc_q    <= m1_pay_q.tc;
      m2_rcm_q   <= m1_rcm_q;
      m2_den_q   <= m1_den_q;
      m2_mp_q    <= mp;
      m2_hs_q    <= hs;
      m2_amag_q  <= a_mag;

      m3_pplo_q  <= {{PROD_SPLIT{1'b0}}, d2_pay.rc_mag}
                  * {{DIF_W{1'b0}}, tphi[PROD_SPLIT-1:0]};
      m3_pphi_q  <= {{HI_W{1'b0}}, d2_pay.rc_mag}
                  * {{DIF_W{1'b0}}, tphi[TPH_W-1:PROD_SPLIT]};
      m3_p2neg_q <= d2_pay.p2_neg;
      m3_last_q  <= d2_pay.last;
      m3_c_q     <= d2_pay.c;
      m3_tc_q    <= d2_pay.tc;
      m3_mp_q    <= d2_pay.mp;
      m3_hs_q    <= d2_pay.hs;

      m4_last_q  <= m3_last_q;
      m4_c_q     <= m3_c_q;
      m4_tc_q    <= m3_tc_q;
      m4_mp_q    <= m3_mp_q;
      m4_hs_q    <= m3_hs_q;
      m4_p2_q    <= p2;

      m5_last_q  <= m4_last_q;
      m5_c_q     <= m4_c_q;
      m5_tc_q    <= m4_tc_q;
      m5_hs_q    <= m4_hs_q;
      m5_ts_q    <= tsum_adj[64:1];
    end
  end

  assign res_valid_o = m5_vld_q;

  always_comb begin
    res_o.left_face          = sat32({{34{m5_c_q[31]}}, m5_c_q}
                                   - {{32{m5_hs_q[DEN_W-1]}}, m5_hs_q});
    res_o.right_face         = sat32({{34{m5_c_q[31]}}, m5_c_q}
                                   + {{32{m5_hs_q[DEN_W-1]}}, m5_hs_q});
    res_o.left_face_tangent  = sat32({{34{m5_tc_q[31]}}, m5_tc_q}
                                   - {{2{m5_ts_q[63]}}, m5_ts_q});
    res_o.right_face_tangent = sat32({{34{m5_tc_q[31]}}, m5_tc_q}
                                   + {{2{m5_ts_q[63]}}, m5_ts_q});
    res_o.last               = m5_last_q;
  end

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m2_vld_q && m2_int_q |-> m2_den_q != '0)
    else $error("derivative divider fed a zero divisor");

  a_den_carried: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d2_vld && d2_pay.interior |-> d2_den != '0)
    else $error("derivative divider lost its divisor");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i && m5_vld_q |=> m5_vld_q && $stable(m5_ts_q) && $stable(m5_hs_q))
    else $error("result stage changed while stalled");

  a_half_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m3_vld_q |-> m3_hs_q[DEN_W-1] == m3_hs_q[DEN_W-2])
    else $error("half slope outside 33-bit range");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import slfr_pkg::*;

  localparam int          FRAC       = 16;
  localparam longint      UNIT       = longint'(1) << FRAC;
  localparam longint unsigned MAG_CAP = 64'd1 << 62;
  localparam int          SETTLE     = 2 * FRAC + 60;
  localparam int          CYCLE_CAP  = 400000;
  localparam int          PER_PHASE  = 410;

  typedef struct {
    item_t it;
    bit    known;
    res_t  want;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [BIAS_W-1:0]  cfg_data_i = '0;
  logic               push = 1'b0;
  logic               full;
  logic signed [31:0] left_value_i = '0;
  logic signed [31:0] center_value_i = '0;
  logic signed [31:0] right_value_i = '0;
  logic signed [31:0] left_tangent_i = '0;
  logic signed [31:0] center_tangent_i = '0;
  logic signed [31:0] right_tangent_i = '0;
  logic               last_component_i = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [31:0] left_face_o;
  logic signed [31:0] right_face_o;
  logic signed [31:0] left_face_tangent_o;
  logic signed [31:0] right_face_tangent_o;
  logic               last_out_o;

  slope_limited_face_reconstruction_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .push(push), .full(full),
    .left_value_i(left_value_i), .center_value_i(center_value_i),
    .right_value_i(right_value_i), .left_tangent_i(left_tangent_i),
    .center_tangent_i(center_tangent_i), .right_tangent_i(right_tangent_i),
    .last_component_i(last_component_i),
    .empty(empty), .pop(pop),
    .left_face_o(left_face_o), .right_face_o(right_face_o),
    .left_face_tangent_o(left_face_tangent_o),
    .right_face_tangent_o(right_face_tangent_o),
    .last_out_o(last_out_o)
  );

  res_t            faces_due[$];
  row_t            rows[$];
  logic [15:0]     bias = BIAS_RST;
  int              errors = 0;
  int              n_sent = 0;
  int              cycles = 0;
  int              rx_stall = 0;
  logic            hold = 1'b0;

  always #10 clk_i = ~clk_i;

  function automatic longint fx_mul(longint a, longint b);
    longint unsigned ua, ub, m;
    ua = (a < 0) ? longint'(-a) : a;
    ub = (b < 0) ? longint'(-b) : b;
    if (ub != 0 && ua > MAG_CAP / ub) m = MAG_CAP;
    else m = ua * ub;
    m = m >> FRAC;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint fx_div(longint n, longint d);
    longint unsigned un, ud, m;
    un = (n < 0) ? longint'(-n) : n;
    ud = (d < 0) ? longint'(-d) : d;
    m = (un << FRAC) / ud;
    return ((n < 0) != (d < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return VAL_MAX;
    if (v < -64'sd2147483648) return VAL_MIN;
    return v[31:0];
  endfunction

  function automatic res_t reconstruct_faces(item_t it, logic [15:0] b);
    longint l, c, r, tl, tc, tr, num, rc, den, q, phi, tphi, hs, ts;
    bit     interior;
    res_t   o;
    l  = longint'($signed(it.left_value));
    c  = longint'($signed(it.center_value));
    r  = longint'($signed(it.right_value));
    tl = longint'($signed(it.left_tangent));
    tc = longint'($signed(it.center_tangent));
    tr = longint'($signed(it.right_tangent));
    num = c - l;
    rc  = r - c;
    den = rc + longint'(b);
    tphi = 0;
    interior = 0;
    if (den == 0) begin
      phi = (num > 0) ? UNIT : 0;
    end else begin
      q = fx_div(num, den);
      if (q <= 0) phi = 0;
      else if (q >= UNIT) phi = UNIT;
      else begin
        phi = q;
        interior = 1;
      end
    end
    if (interior) tphi = fx_div((tc - tl) - fx_mul(phi, tr - tc), den);
    hs = fx_mul(rc, phi) / 2;
    ts = (fx_mul(phi, tr - tc) + fx_mul(rc, tphi)) / 2;
    o.left_face          = clamp32(c - hs);
    o.right_face         = clamp32(c + hs);
    o.left_face_tangent  = clamp32(tc - ts);
    o.right_face_tangent = clamp32(tc + ts);
    o.last               = it.last;
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((n_sent / 64) % 4 == 1 || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] near(logic [31:0] base, int lo, int hi);
    return base + ($signed($urandom) >>> $urandom_range(lo, hi));
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int    mode;
    mode = $urandom_range(0, 9);
    it.last = $urandom_range(0, 1);
    if (mode < 2) begin
      it.left_value = $urandom;   it.center_value = $urandom;
      it.right_value = $urandom;  it.left_tangent = $urandom;
      it.center_tangent = $urandom; it.right_tangent = $urandom;
    end else begin
      it.center_value = near('0, 0, 16);
      it.left_value   = near(it.center_value, 4, 24);
      it.right_value  = (mode == 2) ? it.center_value - {16'd0, bias}
                                    : near(it.center_value, 4, 24);
      it.center_tangent = near('0, 0, 20);
      it.left_tangent   = near(it.center_tangent, 2, 24);
      it.right_tangent  = near(it.center_tangent, 2, 24);
    end
    return it;
  endfunction

  task automatic send_item(item_t it, bit known, res_t want);
    int g;
    g = pick_gap();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    push             <= 1'b1;
    left_value_i     <= it.left_value;
    center_value_i   <= it.center_value;
    right_value_i    <= it.right_value;
    left_tangent_i   <= it.left_tangent;
    center_tangent_i <= it.center_tangent;
    right_tangent_i  <= it.right_tangent;
    last_component_i <= it.last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    faces_due.push_back(known ? want : reconstruct_faces(it, bias));
    n_sent++;
  endtask

  task automatic write_bias(logic [15:0] v);
    push <= 1'b0;
    wait (faces_due.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    bias = v;
  endtask

  task automatic add_row(logic [31:0] l, logic [31:0] c, logic [31:0] r,
                         logic [31:0] tl, logic [31:0] tc, logic [31:0] tr,
                         logic lst, bit known, res_t want);
    row_t w;
    w.it = '{l, c, r, tl, tc, tr, lst};
    w.known = known;
    w.want = want;
    rows.push_back(w);
  endtask

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : rx
    res_t want;
    int   r;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (faces_due.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h %h %h %h %b", $time,
                   left_face_o, right_face_o, left_face_tangent_o,
                   right_face_tangent_o, last_out_o);
          errors++;
        end else begin
          want = faces_due.pop_front();
          check_field("left_face", want.left_face, left_face_o);
          check_field("right_face", want.right_face, right_face_o);
          check_field("left_face_tangent", want.left_face_tangent, left_face_tangent_o);
          check_field("right_face_tangent", want.right_face_tangent, right_face_tangent_o);
          check_field("last_out", {31'd0, want.last}, {31'd0, last_out_o});
        end
      end
      if (hold || rx_stall > 0) begin
        pop <= 1'b0;
        if (rx_stall > 0) rx_stall <= rx_stall - 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) rx_stall <= $urandom_range(10, 60);
        pop <= (r >= 20) || ((n_sent / 64) % 4 == 2);
      end
    end
  end

  initial begin
    wait (n_sent >= 600);
    @(posedge clk_i);
    hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("** slope_limited_face_reconstruction_top: FAILED **");
      $finish;
    end
  end

  initial begin
    res_t nil;
    nil = '0;
    add_row('0, '0, '0, '0, '0, '0, 1'b1, 1, '{'0, '0, '0, '0, 1'b1});
    add_row(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MIN, 1'b0, 1,
            '{VAL_MAX, VAL_MAX, VAL_MIN, VAL_MIN, 1'b0});
    add_row(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MAX, 1'b1, 1,
            '{VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX, 1'b1});
    add_row('0, '0, 32'hffff_ffff, 32'd5, 32'd7, 32'd9, 1'b0, 1,
            '{'0, '0, 32'd7, 32'd7, 1'b0});
    add_row(32'hffff_0000, '0, 32'hffff_ffff, 32'd3, 32'h0002_0000, 32'h0005_0000,
            1'b1, 0, nil);
    add_row('0, 32'h0001_0000, 32'h0002_0000, 32'h0000_4000, 32'h0001_0000,
            32'h0003_0000, 1'b0, 0, nil);
    add_row(VAL_MIN, '0, VAL_MAX, VAL_MAX, '0, VAL_MIN, 1'b1, 0, nil);
    add_row(VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MAX, 1'b0, 0, nil);
    add_row('0, 32'h0001_0000, 32'h0003_0000, VAL_MIN, VAL_MAX, VAL_MIN, 1'b1, 0, nil);
    add_row(32'h0003_0000, 32'h0001_0000, '0, 32'h1234_5678, 32'hfedc_ba98,
            32'h0f0f_0f0f, 1'b0, 0, nil);
    add_row('0, 32'h0001_0000, '0, 32'h11, 32'h22, 32'h33, 1'b1, 1,
            '{32'h0001_0000, 32'h0001_0000, 32'h22, 32'h22, 1'b1});
    add_row(32'h0000_8000, 32'h0001_0000, 32'h0001_0000, 32'haaaa_aaaa,
            32'h5555_5555, 32'haaaa_aaaa, 1'b0, 0, nil);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_item(rows[i].it, rows[i].known, rows[i].want);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_bias(16'd0);
        1: write_bias(16'hffff);
        2: write_bias(16'($urandom_range(2, 65534)));
        default: write_bias(16'd1);
      endcase
      for (int n = 0; n < PER_PHASE; n++) send_item(rand_item(), 0, nil);
    end
    push <= 1'b0;

    wait (faces_due.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("** slope_limited_face_reconstruction_top: PASSED **");
    end else begin
      $display("** slope_limited_face_reconstruction_top: FAILED **");
    end
    $finish;
  end

endmodule
